>>> rtl/core/m6502asu_pkg.sv
// Shared types, op codes and constants of the 6502 address and stack unit.
package m6502asu_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam int IDX_BITS  = 3;

  localparam logic [7:0]  ZERO_PAGE_HI  = 8'h00;
  localparam logic [7:0]  STACK_PAGE_HI = 8'h01;
  localparam logic [15:0] STACK_PAGE    = 16'h0100;

  typedef enum logic [4:0] {
    OP_WRITE  = 5'd0,
    OP_READ   = 5'd1,
    OP_IMM    = 5'd2,
    OP_ZP     = 5'd3,
    OP_ZPX    = 5'd4,
    OP_ZPY    = 5'd5,
    OP_ABS    = 5'd6,
    OP_ABSX   = 5'd7,
    OP_ABSY   = 5'd8,
    OP_IND    = 5'd9,
    OP_INDX   = 5'd10,
    OP_INDY   = 5'd11,
    OP_REL    = 5'd12,
    OP_PUSH   = 5'd13,
    OP_PULL   = 5'd14,
    OP_PUSHW  = 5'd15,
    OP_PULLW  = 5'd16,
    OP_FETCHB = 5'd17,
    OP_FETCHW = 5'd18
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                latch_in;
    logic                mem_en;
    logic                capture;
    logic [IDX_BITS-1:0] acc_idx;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] acc_total;
    logic [IDX_BITS-1:0] in_total;
  } stat_t;

  function automatic logic [IDX_BITS-1:0] acc_count(input logic [4:0] code);
    logic [IDX_BITS-1:0] n;
    unique case (op_t'(code))
      OP_WRITE, OP_READ, OP_ZP, OP_ZPX, OP_ZPY, OP_REL,
      OP_PUSH, OP_PULL, OP_FETCHB:               n = IDX_BITS'(1);
      OP_ABS, OP_ABSX, OP_ABSY, OP_PUSHW,
      OP_PULLW, OP_FETCHW:                       n = IDX_BITS'(2);
      OP_INDX, OP_INDY:                          n = IDX_BITS'(3);
      OP_IND:                                    n = IDX_BITS'(4);
      default:                                   n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/m6502asu_ifs.sv
// Request and result channel interfaces of the 6502 address and stack unit.
interface m6502asu_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic [15:0] prog_counter;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  stack_ptr;
  logic [15:0] mem_addr;
  logic [15:0] data_in;

  modport source (
    output valid, op, prog_counter, index_x, index_y, stack_ptr, mem_addr, data_in,
    input  ready
  );
  modport sink (
    input  valid, op, prog_counter, index_x, index_y, stack_ptr, mem_addr, data_in,
    output ready
  );
endinterface

interface m6502asu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] eff_addr;
  logic [15:0] data_out;
  logic [15:0] next_pc;
  logic [7:0]  next_sp;
  logic        page_cross;

  modport source (
    output valid, eff_addr, data_out, next_pc, next_sp, page_cross,
    input  ready
  );
  modport sink (
    input  valid, eff_addr, data_out, next_pc, next_sp, page_cross,
    output ready
  );
endinterface

>>> rtl/core/m6502asu_ram.sv
// Generic single-port RAM with registered read.
module m6502asu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/m6502asu_ctrl.sv
// Sequencer of the 6502 address and stack unit: handshakes and memory access steps.
module m6502asu_ctrl
  import m6502asu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t              state, state_next;
  logic [IDX_BITS-1:0] idx, idx_next;
  logic                rsp_valid_next;
  logic                load;

  assign load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (req_valid) begin
          state_next = (stat.in_total == '0) ? S_DONE : S_ACCESS;
        end
      end
      S_ACCESS: begin
        idx_next = idx + IDX_BITS'(1);
        if (idx_next == stat.acc_total) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = (state == S_IDLE);
    cmd.latch_in = (state == S_IDLE) && req_valid;
    cmd.mem_en   = (state == S_ACCESS);
    cmd.capture  = (state == S_ACCESS);
    cmd.acc_idx  = idx;
    cmd.load_out = load;
    if (load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE))
    else $error("accepted transaction did not start work");

  a_access_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCESS) |-> (idx < stat.acc_total))
    else $error("memory step beyond the op's access count");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (idx == stat.acc_total))
    else $error("result formed before all memory steps finished");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DONE))
    else $error("result valid raised outside completion");

endmodule

>>> rtl/core/m6502asu_dp.sv
// Datapath of the 6502 address and stack unit: operand registers, memory and address math.
module m6502asu_dp
  import m6502asu_pkg::*;
(
  input  logic        clk,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [4:0]  op,
  input  logic [15:0] prog_counter,
  input  logic [7:0]  index_x,
  input  logic [7:0]  index_y,
  input  logic [7:0]  stack_ptr,
  input  logic [15:0] mem_addr,
  input  logic [15:0] data_in,
  output logic [15:0] eff_addr,
  output logic [15:0] data_out,
  output logic [15:0] next_pc,
  output logic [7:0]  next_sp,
  output logic        page_cross
);

  logic [4:0]  opc;
  logic [15:0] pc;
  logic [7:0]  xr;
  logic [7:0]  yr;
  logic [7:0]  sp;
  logic [15:0] ma;
  logic [15:0] din;
  logic [7:0]  rb [4];
  logic [7:0]  b  [4];

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_a;
  logic [7:0]           mem_wd;
  logic [7:0]           rdata;

  logic [7:0]  sp_p1, sp_p2, sp_m1, sp_m2;
  logic [7:0]  zp_ptr;
  logic [15:0] pc_p1, pc_p2, pc_step;
  logic [15:0] base;
  logic [15:0] res_ea, res_dout, res_npc;
  logic [7:0]  res_nsp;
  logic        res_pcr;

  assign stat.acc_total = acc_count(opc);
  assign stat.in_total  = acc_count(op);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      opc <= op;
      pc  <= prog_counter;
      xr  <= index_x;
      yr  <= index_y;
      sp  <= stack_ptr;
      ma  <= mem_addr;
      din <= data_in;
    end
    if (cmd.capture) begin
      for (int j = 0; j < 4; j++) begin
        if (cmd.acc_idx == IDX_BITS'(j + 1)) begin
          rb[j] <= rdata;
        end
      end
    end
    if (cmd.load_out) begin
      eff_addr   <= res_ea;
      data_out   <= res_dout;
      next_pc    <= res_npc;
      next_sp    <= res_nsp;
      page_cross <= res_pcr;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      b[j] = (cmd.acc_idx == IDX_BITS'(j + 1)) ? rdata : rb[j];
    end
  end

  assign sp_p1   = sp + 8'd1;
  assign sp_p2   = sp + 8'd2;
  assign sp_m1   = sp - 8'd1;
  assign sp_m2   = sp - 8'd2;
  assign pc_p1   = pc + 16'd1;
  assign pc_p2   = pc + 16'd2;
  assign pc_step = pc + 16'(cmd.acc_idx);
  assign zp_ptr  = b[0] + xr;

  m6502asu_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .en    (cmd.mem_en),
    .we    (mem_we),
    .addr  (mem_a),
    .wdata (mem_wd),
    .rdata (rdata)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wd = din[7:0];
    mem_a  = pc_step;
    unique case (op_t'(opc))
      OP_WRITE: begin
        mem_we = 1'b1;
        mem_a  = ma;
      end
      OP_READ: mem_a = ma;
      OP_IND: begin
        if (cmd.acc_idx == IDX_BITS'(2)) begin
          mem_a = {b[1], b[0]};
        end else if (cmd.acc_idx == IDX_BITS'(3)) begin
          mem_a = {b[1], b[0] + 8'd1};
        end
      end
      OP_INDX: begin
        if (cmd.acc_idx == IDX_BITS'(1)) begin
          mem_a = {ZERO_PAGE_HI, zp_ptr};
        end else if (cmd.acc_idx == IDX_BITS'(2)) begin
          mem_a = {ZERO_PAGE_HI, zp_ptr + 8'd1};
        end
      end
      OP_INDY: begin
        if (cmd.acc_idx == IDX_BITS'(1)) begin
          mem_a = {ZERO_PAGE_HI, b[0]};
        end else if (cmd.acc_idx == IDX_BITS'(2)) begin
          mem_a = {ZERO_PAGE_HI, b[0] + 8'd1};
        end
      end
      OP_PUSH: begin
        mem_we = 1'b1;
        mem_a  = {STACK_PAGE_HI, sp};
      end
      OP_PULL: mem_a = {STACK_PAGE_HI, sp_p1};
      OP_PUSHW: begin
        mem_we = 1'b1;
        if (cmd.acc_idx == '0) begin
          mem_a  = {STACK_PAGE_HI, sp};
          mem_wd = din[15:8];
        end else begin
          mem_a  = {STACK_PAGE_HI, sp_m1};
        end
      end
      OP_PULLW: begin
        mem_a = (cmd.acc_idx == '0) ? {STACK_PAGE_HI, sp_p1} : {STACK_PAGE_HI, sp_p2};
      end
      default: mem_a = pc_step;
    endcase
  end

  always_comb begin
    res_ea   = '0;
    res_dout = '0;
    res_npc  = pc;
    res_nsp  = sp;
    res_pcr  = 1'b0;
    base     = {b[1], b[0]};
    unique case (op_t'(opc))
      OP_WRITE: begin
        res_ea   = ma;
        res_dout = {8'h00, din[7:0]};
      end
      OP_READ: begin
        res_ea   = ma;
        res_dout = {8'h00, b[0]};
      end
      OP_IMM: begin
        res_ea  = pc;
        res_npc = pc_p1;
      end
      OP_ZP: begin
        res_ea  = {ZERO_PAGE_HI, b[0]};
        res_npc = pc_p1;
      end
      OP_ZPX: begin
        res_ea  = {ZERO_PAGE_HI, b[0] + xr};
        res_npc = pc_p1;
      end
      OP_ZPY: begin
        res_ea  = {ZERO_PAGE_HI, b[0] + yr};
        res_npc = pc_p1;
      end
      OP_ABS: begin
        res_ea  = base;
        res_npc = pc_p2;
      end
      OP_ABSX: begin
        res_ea  = base + {8'h00, xr};
        res_pcr = (res_ea[15:8] != base[15:8]);
        res_npc = pc_p2;
      end
      OP_ABSY: begin
        res_ea  = base + {8'h00, yr};
        res_pcr = (res_ea[15:8] != base[15:8]);
        res_npc = pc_p2;
      end
      OP_IND: begin
        res_ea  = {b[3], b[2]};
        res_npc = pc_p2;
      end
      OP_INDX: begin
        res_ea  = {b[2], b[1]};
        res_npc = pc_p1;
      end
      OP_INDY: begin
        base    = {b[2], b[1]};
        res_ea  = base + {8'h00, yr};
        res_pcr = (res_ea[15:8] != base[15:8]);
        res_npc = pc_p1;
      end
      OP_REL: begin
        res_ea  = pc_p1 + {{8{b[0][7]}}, b[0]};
        res_npc = pc_p1;
      end
      OP_PUSH: begin
        res_ea  = STACK_PAGE | {8'h00, sp};
        res_nsp = sp_m1;
      end
      OP_PULL: begin
        res_ea   = STACK_PAGE | {8'h00, sp_p1};
        res_dout = {8'h00, b[0]};
        res_nsp  = sp_p1;
      end
      OP_PUSHW: begin
        res_ea  = STACK_PAGE | {8'h00, sp_m1};
        res_nsp = sp_m2;
      end
      OP_PULLW: begin
        res_ea   = STACK_PAGE | {8'h00, sp_p1};
        res_dout = {b[1], b[0]};
        res_nsp  = sp_p2;
      end
      OP_FETCHB: begin
        res_ea   = pc;
        res_dout = {8'h00, b[0]};
        res_npc  = pc_p1;
      end
      OP_FETCHW: begin
        res_ea   = pc;
        res_dout = {b[1], b[0]};
        res_npc  = pc_p2;
      end
      default: res_ea = '0;
    endcase
  end

endmodule

>>> rtl/core/mos6502_address_and_stack_unit.sv
// Top level of the 6502 address and stack unit: byte memory, addressing modes and stack ops.
//
// Channels: req carries one op with PC, X, Y, SP, an address and data; rsp returns
// the effective address, output data, next PC, next SP and the page-cross flag.
// Both use valid/ready; a transaction moves when both are high at a clock edge.
// One result follows every request, in order.
// An op makes 0 to 4 accesses to a single-port 64K x 8 memory, one per cycle,
// each address possibly built from the byte read just before. Immediate and
// unused codes make no access; read/write/zero page/relative/push/pull/byte
// fetch make one; absolute and absolute indexed, word fetch and word stack ops
// make two; indexed indirect and indirect indexed make three; indirect makes
// four. The next request is taken only once the result is registered, so the
// unit does not start a new request before it is through with the last one.
// The result sits in an output register: a stalled receiver holds the result,
// while the unit still takes and works on one more request, then waits.
// Reset (rst, synchronous) clears the sequencer and the result valid flag; the
// memory content is not cleared, and a byte read before it was written is unknown.
module mos6502_address_and_stack_unit
  import m6502asu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  m6502asu_req_if.sink          req,
  m6502asu_rsp_if.source        rsp
);

  cmd_t  cmd;
  stat_t stat;

  m6502asu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  m6502asu_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .op           (req.op),
    .prog_counter (req.prog_counter),
    .index_x      (req.index_x),
    .index_y      (req.index_y),
    .stack_ptr    (req.stack_ptr),
    .mem_addr     (req.mem_addr),
    .data_in      (req.data_in),
    .eff_addr     (rsp.eff_addr),
    .data_out     (rsp.data_out),
    .next_pc      (rsp.next_pc),
    .next_sp      (rsp.next_sp),
    .page_cross   (rsp.page_cross)
  );

endmodule
